### rtl/egcd_pkg.sv
// shared types and constants for the extended gcd block
package egcd_pkg;

  localparam int FIELD_WIDTH = 63;
  localparam int COEFF_WIDTH = 64;

  typedef struct packed {
    logic load;
    logic start_div;
    logic div_step;
    logic update;
    logic capture;
  } egcd_cmd_t;

  typedef struct packed {
    logic r1_zero;
  } egcd_sts_t;

endpackage

### rtl/egcd_dp.sv
// datapath: remainder and coefficient registers, bit-serial divider with product accumulation
module egcd_dp #(
  parameter int W = 63
) (
  input  logic                                     clk,
  input  egcd_pkg::egcd_cmd_t                      cmd,
  output egcd_pkg::egcd_sts_t                      sts,
  input  logic [egcd_pkg::FIELD_WIDTH-1:0]         in_first_value,
  input  logic [egcd_pkg::FIELD_WIDTH-1:0]         in_second_value,
  output logic [egcd_pkg::FIELD_WIDTH-1:0]         out_divisor_out,
  output logic signed [egcd_pkg::COEFF_WIDTH-1:0]  out_coeff_first,
  output logic signed [egcd_pkg::COEFF_WIDTH-1:0]  out_coeff_second
);
  import egcd_pkg::*;

  logic [W-1:0]           r0_r, r1_r, rem_r, dvd_r;
  logic [W-1:0]           r0_nxt, r1_nxt, rem_nxt, dvd_nxt;
  logic [COEFF_WIDTH-1:0] s0_r, s1_r, t0_r, t1_r, ps_r, pt_r;
  logic [COEFF_WIDTH-1:0] s0_nxt, s1_nxt, t0_nxt, t1_nxt, ps_nxt, pt_nxt;
  logic [FIELD_WIDTH-1:0] gcd_r;
  logic [COEFF_WIDTH-1:0] cs_r, ct_r;
  logic [W:0]             partial;
  logic [W:0]             diff;
  logic                   qbit;

  assign partial = {rem_r, dvd_r[W-1]};
  assign diff    = partial - {1'b0, r1_r};
  assign qbit    = ~diff[W];

  always_comb begin
    r0_nxt  = r0_r;
    r1_nxt  = r1_r;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    s0_nxt  = s0_r;
    s1_nxt  = s1_r;
    t0_nxt  = t0_r;
    t1_nxt  = t1_r;
    ps_nxt  = ps_r;
    pt_nxt  = pt_r;
    if (cmd.load) begin
      r0_nxt = in_first_value[W-1:0];
      r1_nxt = in_second_value[W-1:0];
      s0_nxt = COEFF_WIDTH'(1);
      s1_nxt = '0;
      t0_nxt = '0;
      t1_nxt = COEFF_WIDTH'(1);
    end
    if (cmd.start_div) begin
      rem_nxt = '0;
      dvd_nxt = r0_r;
      ps_nxt  = '0;
      pt_nxt  = '0;
    end
    if (cmd.div_step) begin
      rem_nxt = qbit ? diff[W-1:0] : partial[W-1:0];
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      // quotient bits arrive msb first, so q*s builds by shift and add
      ps_nxt  = {ps_r[COEFF_WIDTH-2:0], 1'b0} + (qbit ? s1_r : '0);
      pt_nxt  = {pt_r[COEFF_WIDTH-2:0], 1'b0} + (qbit ? t1_r : '0);
    end
    if (cmd.update) begin
      r0_nxt = r1_r;
      r1_nxt = rem_r;
      s0_nxt = s1_r;
      s1_nxt = s0_r - ps_r;
      t0_nxt = t1_r;
      t1_nxt = t0_r - pt_r;
    end
  end

  always_ff @(posedge clk) begin
    r0_r  <= r0_nxt;
    r1_r  <= r1_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    s0_r  <= s0_nxt;
    s1_r  <= s1_nxt;
    t0_r  <= t0_nxt;
    t1_r  <= t1_nxt;
    ps_r  <= ps_nxt;
    pt_r  <= pt_nxt;
    if (cmd.capture) begin
      gcd_r <= FIELD_WIDTH'(r0_r);
      cs_r  <= s0_r;
      ct_r  <= t0_r;
    end
  end

  assign sts.r1_zero      = (r1_r == '0);
  assign out_divisor_out  = gcd_r;
  assign out_coeff_first  = cs_r;
  assign out_coeff_second = ct_r;

endmodule

### rtl/egcd_ctrl.sv
// controller: sequences euclid rounds and the divider, owns the handshakes
module egcd_ctrl #(
  parameter int W = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output egcd_pkg::egcd_cmd_t cmd,
  input  egcd_pkg::egcd_sts_t sts
);
  import egcd_pkg::*;

  localparam int CW = $clog2(W);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          in_take;
  logic          out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.r1_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.start_div = 1'b1;
          cnt_nxt       = CW'(W - 1);
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_UPDATE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_take_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_CHECK)
    else $error("accepted word did not start a round check");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && cnt_r == '0 |=> state_r == ST_UPDATE)
    else $error("divider did not hand over to update");

  a_capture_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> out_valid_r && state_r == ST_IDLE)
    else $error("captured result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

endmodule

### rtl/extended_gcd.sv
// extended gcd top level: gcd and bezout coefficients of two unsigned operands
// each round runs the one-bit-per-cycle divider over OPERAND_WIDTH quotient bits plus check and update
// one operand pair in work at a time; a new word is taken while the last result waits
// rst_n synchronous active low clears the controller and output valid; data registers are not reset
module extended_gcd #(
  parameter int OPERAND_WIDTH = 63
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [egcd_pkg::FIELD_WIDTH-1:0]         in_first_value,
  input  logic [egcd_pkg::FIELD_WIDTH-1:0]         in_second_value,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [egcd_pkg::FIELD_WIDTH-1:0]         out_divisor_out,
  output logic signed [egcd_pkg::COEFF_WIDTH-1:0]  out_coeff_first,
  output logic signed [egcd_pkg::COEFF_WIDTH-1:0]  out_coeff_second
);
  import egcd_pkg::*;

  egcd_cmd_t cmd;
  egcd_sts_t sts;

  egcd_ctrl #(.W(OPERAND_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  egcd_dp #(.W(OPERAND_WIDTH)) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .in_first_value   (in_first_value),
    .in_second_value  (in_second_value),
    .out_divisor_out  (out_divisor_out),
    .out_coeff_first  (out_coeff_first),
    .out_coeff_second (out_coeff_second)
  );

endmodule

### sim/egcd_checker.sv
// checker for extended_gcd: predicts gcd and bezout coefficients and compares result words
module egcd_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic [egcd_pkg::FIELD_WIDTH-1:0]        in_first_value,
  input  logic [egcd_pkg::FIELD_WIDTH-1:0]        in_second_value,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic [egcd_pkg::FIELD_WIDTH-1:0]        out_divisor_out,
  input  logic signed [egcd_pkg::COEFF_WIDTH-1:0] out_coeff_first,
  input  logic signed [egcd_pkg::COEFF_WIDTH-1:0] out_coeff_second,
  output int unsigned                             fail_count,
  output int unsigned                             pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  import egcd_pkg::*;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0]        gcd;
    logic signed [COEFF_WIDTH-1:0] coeff_a;
    logic signed [COEFF_WIDTH-1:0] coeff_b;
  } bezout_t;

  bezout_t bezout_q[$];

  initial begin
    fail_count    = 0;
    pending_words = 0;
  end

  function automatic bezout_t euclid_result(input logic [FIELD_WIDTH-1:0] a,
                                            input logic [FIELD_WIDTH-1:0] b);
    logic [COEFF_WIDTH-1:0] r0, r1, r2, q;
    logic [COEFF_WIDTH-1:0] s0, s1, s2, t0, t1, t2;
    bezout_t res;
    r0 = COEFF_WIDTH'(a);
    r1 = COEFF_WIDTH'(b);
    s0 = 1;
    s1 = 0;
    t0 = 0;
    t1 = 1;
    // coefficients wrap modulo 2^64, final values are exact
    while (r1 != 0) begin
      q  = r0 / r1;
      r2 = r0 % r1;
      s2 = s0 - q * s1;
      t2 = t0 - q * t1;
      r0 = r1;
      r1 = r2;
      s0 = s1;
      s1 = s2;
      t0 = t1;
      t1 = t2;
    end
    res.gcd     = r0[FIELD_WIDTH-1:0];
    res.coeff_a = s0;
    res.coeff_b = t0;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    bezout_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (bezout_q.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending: gcd %0d x %0d y %0d",
                                    out_divisor_out, out_coeff_first, out_coeff_second));
        end else begin
          want = bezout_q.pop_front();
          if (out_divisor_out !== want.gcd)
            report_mismatch($sformatf("gcd: got %0d, want %0d", out_divisor_out, want.gcd));
          if (out_coeff_first !== want.coeff_a)
            report_mismatch($sformatf("coeff_first: got %0d, want %0d",
                                      out_coeff_first, want.coeff_a));
          if (out_coeff_second !== want.coeff_b)
            report_mismatch($sformatf("coeff_second: got %0d, want %0d",
                                      out_coeff_second, want.coeff_b));
        end
      end
      if (in_valid && !in_stall)
        bezout_q.push_back(euclid_result(in_first_value, in_second_value));
    end
    pending_words <= bezout_q.size();
  end

endmodule

### sim/tb_extended_gcd.sv
// testbench top for extended_gcd: clock, reset, operand stimulus, result stalls and verdict
module tb_extended_gcd;
  timeunit 1ns;
  timeprecision 1ps;

  import egcd_pkg::*;

  typedef logic [FIELD_WIDTH-1:0] operand_t;

  localparam operand_t    MAX_OPND    = '1;
  localparam operand_t    FIB_92      = 63'd7540113804746346429;
  localparam operand_t    FIB_91      = 63'd4660046610375530309;
  localparam int unsigned QUIET_LIMIT = 40000;
  localparam int          PHASE_WORDS = 434;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  operand_t                      in_first_value = '0;
  operand_t                      in_second_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  operand_t                      out_divisor_out;
  logic signed [COEFF_WIDTH-1:0] out_coeff_first;
  logic signed [COEFF_WIDTH-1:0] out_coeff_second;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned quiet_cycles = 0;
  int unsigned send_pct = 10;
  int unsigned recv_pct = 80;

  extended_gcd dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_value   (in_first_value),
    .in_second_value  (in_second_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_divisor_out  (out_divisor_out),
    .out_coeff_first  (out_coeff_first),
    .out_coeff_second (out_coeff_second)
  );

  egcd_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_value   (in_first_value),
    .in_second_value  (in_second_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_divisor_out  (out_divisor_out),
    .out_coeff_first  (out_coeff_first),
    .out_coeff_second (out_coeff_second),
    .fail_count       (fail_count),
    .pending_words    (pending_words)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic operand_t rand_bits(input int unsigned len);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if (len < 63)
      raw = raw & ((64'd1 << len) - 64'd1);
    return raw[FIELD_WIDTH-1:0];
  endfunction

  function automatic operand_t rand_operand();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 4)
      return '0;
    else if (sel < 8)
      return MAX_OPND - operand_t'($urandom_range(3));
    else if (sel < 40)
      return rand_bits(63);
    else
      return rand_bits($urandom_range(1, 63));
  endfunction

  task automatic send_word(input operand_t a, input operand_t b);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_first_value  <= a;
    in_second_value <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random_word();
    operand_t    a, b, g, fa, fb, nxt;
    int unsigned sel, len, k;
    sel = $urandom_range(99);
    if (sel < 10) begin
      // consecutive fibonacci numbers, the longest chains of rounds
      k  = $urandom_range(2, 91);
      fa = 0;
      fb = 1;
      repeat (k) begin
        nxt = fa + fb;
        fa  = fb;
        fb  = nxt;
      end
      if ($urandom_range(1)) begin
        a = fb;
        b = fa;
      end else begin
        a = fa;
        b = fb;
      end
    end else if (sel < 30) begin
      // shared factor so the gcd is large
      len = $urandom_range(1, 40);
      g   = rand_bits(len);
      a   = operand_t'(64'(g) * 64'(rand_bits($urandom_range(1, 63 - len))));
      b   = operand_t'(64'(g) * 64'(rand_bits($urandom_range(1, 63 - len))));
    end else if (sel < 38) begin
      b = rand_bits($urandom_range(1, 40));
      a = operand_t'(64'(b) * 64'($urandom_range(1, 1000)));
      if ($urandom_range(1))
        {a, b} = {b, a};
    end else begin
      a = rand_operand();
      b = rand_operand();
    end
    send_word(a, b);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(0, 0);
    send_word(5, 0);
    send_word(0, 7);
    send_word(MAX_OPND, 0);
    send_word(0, MAX_OPND);
    send_word(MAX_OPND, MAX_OPND);
    send_word(1, 1);
    send_word(MAX_OPND, 1);
    send_word(1, MAX_OPND);
    send_word(12, 18);
    send_word(18, 12);
    send_word(FIB_92, FIB_91);
    send_word(FIB_91, FIB_92);
    send_word(MAX_OPND, MAX_OPND - 1);
    send_word(63'h4000_0000_0000_0000, 63'h2000_0000_0000_0000);
    send_word(MAX_OPND, 63'h4000_0000_0000_0000);
    send_word(63'h4000_0000_0000_0000, 3);
    send_word(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
    send_word(6, 3);
    send_word(3, 6);
    send_word(1, 0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_pct = 10;
          recv_pct = 80;
        end
        1: begin
          send_pct = 80;
          recv_pct = 10;
        end
        default: begin
          send_pct = 0;
          recv_pct = 0;
        end
      endcase
      repeat (PHASE_WORDS) send_random_word();
    end
    in_valid <= 1'b0;

    while (pending_words != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
